/* rtl/btts_pkg.sv */
// ----------------------------------------------------------------------------
// btts_pkg
// Shared widths, constants and types for the buzzer tone timer setup block.
// ----------------------------------------------------------------------------
package btts_pkg;

  localparam int unsigned CLK_W     = 32;
  localparam int unsigned FREQ_IN_W = 32;
  localparam int unsigned VOL_IN_W  = 16;
  localparam int unsigned FREQ_W    = 14;
  localparam int unsigned VOL_W     = 7;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PULSE_W   = 15;
  // divisor is freq * factor, at most 20000
  localparam int unsigned DSR_W     = 15;

  localparam logic [CLK_W-1:0]  CLOCK_RESET_HZ = 32'd168000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX_HZ    = 14'd10000;
  localparam logic [FREQ_W-1:0] FREQ_MIN_HZ    = 14'd200;
  localparam logic [FREQ_W-1:0] FREQ_LOW_HZ    = 14'd500;
  localparam logic [FREQ_W-1:0] FREQ_MID_HZ    = 14'd2000;
  localparam logic [VOL_W-1:0]  VOLUME_MAX     = 7'd100;

  localparam logic [2:0] FACTOR_LOW  = 3'd4;
  localparam logic [2:0] FACTOR_MID  = 3'd3;
  localparam logic [2:0] FACTOR_HIGH = 3'd2;

  // period / 200 == (period >> 3) / 25; 25 done as multiply by ceil(2^17/25)
  localparam int unsigned   RECIP_SHIFT = 17;
  localparam logic [12:0]   RECIP_25    = 13'd5243;
  localparam int unsigned   PDIV_W      = 9;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
  } side_t;

endpackage

/* rtl/btts_div_pipe.sv */
// ----------------------------------------------------------------------------
// btts_div_pipe
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with a
// sideband that travels along with each request.
// ----------------------------------------------------------------------------
module btts_div_pipe
  import btts_pkg::*;
#(
  parameter int unsigned DIV_STEP = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CLK_W-1:0] in_dividend,
  input  logic [DSR_W-1:0] in_divisor,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CLK_W-1:0] out_quot,
  output side_t            out_side
);

  localparam int unsigned STAGES = CLK_W / DIV_STEP;

  typedef struct packed {
    logic [DSR_W-1:0] rem;
    logic [CLK_W-1:0] dq;   // dividend bits shift out, quotient bits shift in
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [DSR_W-1:0] d);
    div_st_t      r;
    logic [DSR_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t    = {r.rem, r.dq[CLK_W-1]};
      r.dq = {r.dq[CLK_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem   = DSR_W'(t - {1'b0, d});
        r.dq[0] = 1'b1;
      end else begin
        r.rem = t[DSR_W-1:0];
      end
    end
    return r;
  endfunction

  logic    [STAGES-1:0] v;
  logic    [STAGES:0]   rdy;
  div_st_t              st   [STAGES];
  logic [DSR_W-1:0]     dsr  [STAGES];
  side_t                side [STAGES];

  logic    [STAGES-1:0] src_v;
  div_st_t              src_st   [STAGES];
  logic [DSR_W-1:0]     src_dsr  [STAGES];
  side_t                src_side [STAGES];

  assign rdy[STAGES] = out_ready;

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign src_v[g]       = in_valid;
        assign src_st[g].rem  = '0;
        assign src_st[g].dq   = in_dividend;
        assign src_dsr[g]     = in_divisor;
        assign src_side[g]    = in_side;
      end else begin : g_rest
        assign src_v[g]    = v[g-1];
        assign src_st[g]   = st[g-1];
        assign src_dsr[g]  = dsr[g-1];
        assign src_side[g] = side[g-1];
      end

      // a stage takes a new request when empty or when its own moves on
      assign rdy[g] = !v[g] || rdy[g+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (rdy[g]) begin
          v[g] <= src_v[g];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          st[g]   <= div_step(src_st[g], src_dsr[g]);
          dsr[g]  <= src_dsr[g];
          side[g] <= src_side[g];
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v[STAGES-1];
  assign out_quot  = st[STAGES-1].dq;
  assign out_side  = side[STAGES-1];

endmodule

/* rtl/buzzer_tone_timer_setup.sv */
// ----------------------------------------------------------------------------
// buzzer_tone_timer_setup
// Turns a tone frequency and volume request into PWM timer period and
// compare values.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with tone_freq_hz and loudness. A
// request is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with period_count, pulse_count,
// freq_applied, volume_applied and period_overflow; taken the same way.
// cfg_wr_en / cfg_wr_data write core_clock_hz (the dividend); write it
// only while no request is in flight.
// Pipeline: 12 register stages with DIV_STEP = 4 (1 clamp stage +
// 32/DIV_STEP divider stages + 3 stages for period, /200 reciprocal
// multiply and volume multiply); the outputs are driven straight from
// the last stage's registers.
// Throughput: one request per cycle while out_stall stays low; every stage
// is registered and valid bits move with the data.
// Reset: clears all valid bits and loads core_clock_hz with 168000000.
// Out stall: requests pile up into empty stages; in_stall rises only once
// every stage holds a request, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module buzzer_tone_timer_setup
  import btts_pkg::*;
#(
  parameter int unsigned DIV_STEP = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CLK_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FREQ_IN_W-1:0] tone_freq_hz,
  input  logic [VOL_IN_W-1:0]  loudness,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PERIOD_W-1:0]  period_count,
  output logic [PULSE_W-1:0]   pulse_count,
  output logic [FREQ_W-1:0]    freq_applied,
  output logic [VOL_W-1:0]     volume_applied,
  output logic                 period_overflow
);

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                ovf;
    side_t               side;
  } res_t;

  logic [CLK_W-1:0] core_clock_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz <= CLOCK_RESET_HZ;
    end else if (cfg_wr_en) begin
      core_clock_hz <= cfg_wr_data;
    end
  end

  // ---- clamp stage
  logic [FREQ_W-1:0] freq_c;
  logic [VOL_W-1:0]  vol_c;
  logic [2:0]        factor;
  logic [16:0]       dsr_prod;

  always_comb begin
    if (tone_freq_hz > FREQ_IN_W'(FREQ_MAX_HZ)) begin
      freq_c = FREQ_MAX_HZ;
    end else if (tone_freq_hz < FREQ_IN_W'(FREQ_MIN_HZ)) begin
      freq_c = FREQ_MIN_HZ;
    end else begin
      freq_c = tone_freq_hz[FREQ_W-1:0];
    end
    if (loudness > VOL_IN_W'(VOLUME_MAX)) begin
      vol_c = VOLUME_MAX;
    end else begin
      vol_c = loudness[VOL_W-1:0];
    end
    if (freq_c < FREQ_LOW_HZ) begin
      factor = FACTOR_LOW;
    end else if (freq_c < FREQ_MID_HZ) begin
      factor = FACTOR_MID;
    end else begin
      factor = FACTOR_HIGH;
    end
    dsr_prod = 17'(freq_c) * 17'(factor);
  end

  logic             s0_v;
  logic             s0_rdy;
  logic [CLK_W-1:0] s0_dividend;
  logic [DSR_W-1:0] s0_dsr;
  side_t            s0_side;
  logic             div_in_rdy;

  assign s0_rdy   = !s0_v || div_in_rdy;
  assign in_stall = !s0_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      s0_dividend  <= core_clock_hz;
      s0_dsr       <= dsr_prod[DSR_W-1:0];
      s0_side.freq <= freq_c;
      s0_side.vol  <= vol_c;
    end
  end

  // ---- divider
  logic             dv_v;
  logic [CLK_W-1:0] dv_quot;
  side_t            dv_side;
  logic             p_rdy;

  btts_div_pipe #(
    .DIV_STEP (DIV_STEP)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s0_v),
    .in_ready    (div_in_rdy),
    .in_dividend (s0_dividend),
    .in_divisor  (s0_dsr),
    .in_side     (s0_side),
    .out_valid   (dv_v),
    .out_ready   (p_rdy),
    .out_quot    (dv_quot),
    .out_side    (dv_side)
  );

  // ---- period / overflow, /200 reciprocal and volume multiply stages
  logic p_v;
  res_t p_res;
  logic r_v;
  logic r_rdy;
  res_t r_res;
  logic [PDIV_W-1:0] r_pdiv;
  logic m_v;
  logic m_rdy;
  res_t m_res;
  logic [PULSE_W-1:0] m_pulse;
  logic [25:0] recip_prod;
  logic [15:0] pulse_prod;

  assign p_rdy = !p_v || r_rdy;
  assign r_rdy = !r_v || m_rdy;
  assign m_rdy = !m_v || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      r_v <= 1'b0;
      m_v <= 1'b0;
    end else begin
      if (p_rdy) p_v <= dv_v;
      if (r_rdy) r_v <= p_v;
      if (m_rdy) m_v <= r_v;
    end
  end

  assign recip_prod = 26'(p_res.period[PERIOD_W-1:3]) * 26'(RECIP_25);
  assign pulse_prod = 16'(r_pdiv) * 16'(r_res.side.vol);

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      p_res.period <= dv_quot[PERIOD_W-1:0] - PERIOD_W'(1);
      // quotient of zero wraps the period, so it is flagged too
      p_res.ovf    <= (dv_quot[CLK_W-1:PERIOD_W] != '0) || (dv_quot == '0);
      p_res.side   <= dv_side;
    end
    if (r_rdy) begin
      r_res  <= p_res;
      r_pdiv <= recip_prod[RECIP_SHIFT +: PDIV_W];
    end
    if (m_rdy) begin
      m_res   <= r_res;
      m_pulse <= pulse_prod[PULSE_W-1:0];
    end
  end

  assign out_valid       = m_v;
  assign period_count    = m_res.period;
  assign pulse_count     = m_pulse;
  assign freq_applied    = m_res.side.freq;
  assign volume_applied  = m_res.side.vol;
  assign period_overflow = m_res.ovf;

  // ---- checks
  a_freq_band: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (freq_applied >= FREQ_MIN_HZ) && (freq_applied <= FREQ_MAX_HZ))
    else $error("freq_applied outside clamp band");

  a_vol_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> volume_applied <= VOLUME_MAX)
    else $error("volume_applied above limit");

  a_pulse_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pulse_count <= PULSE_W'(32700))
    else $error("pulse_count above largest possible value");

  a_no_ovf_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !period_overflow) |-> period_count != '1)
    else $error("in-range quotient gave wrapped period");

  a_zero_vol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (volume_applied == '0)) |-> pulse_count == '0)
    else $error("nonzero pulse at zero volume");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks buzzer_tone_timer_setup against a cycle-free model of the period,
// compare and clamp arithmetic. Directed band-edge and overflow requests come
// first, then random requests under several core clock settings and random
// sender/receiver idling, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import btts_pkg::*;

  localparam int PIPE_LATENCY = 12;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_LEN     = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int SEG_ITEMS    = 214;
  localparam int PULSE_DIV    = 200;

  typedef struct packed {
    logic [FREQ_IN_W-1:0] freq;
    logic [VOL_IN_W-1:0]  vol;
  } tone_req_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PULSE_W-1:0]  pulse;
    logic [FREQ_W-1:0]   freq;
    logic [VOL_W-1:0]    vol;
    logic                ovf;
  } timer_setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CLK_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FREQ_IN_W-1:0] tone_freq_hz = '0;
  logic [VOL_IN_W-1:0]  loudness = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PERIOD_W-1:0]  period_count;
  logic [PULSE_W-1:0]   pulse_count;
  logic [FREQ_W-1:0]    freq_applied;
  logic [VOL_W-1:0]     volume_applied;
  logic                 period_overflow;

  tone_req_t      tone_req_q[$];
  timer_setting_t timer_setting_q[$];
  logic [CLK_W-1:0] core_clock_model = CLOCK_RESET_HZ;

  logic in_took = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  buzzer_tone_timer_setup DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .tone_freq_hz    (tone_freq_hz),
    .loudness        (loudness),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .period_count    (period_count),
    .pulse_count     (pulse_count),
    .freq_applied    (freq_applied),
    .volume_applied  (volume_applied),
    .period_overflow (period_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic timer_setting_t calc_timer_setting(input logic [CLK_W-1:0] clock_hz,
                                                        input tone_req_t req);
    logic [31:0]   f;
    logic [31:0]   v;
    logic [31:0]   factor;
    logic [31:0]   quot;
    logic [31:0]   pulse;
    logic [15:0]   period;
    timer_setting_t r;
    f = req.freq;
    if (f > 32'(FREQ_MAX_HZ)) f = 32'(FREQ_MAX_HZ);
    else if (f < 32'(FREQ_MIN_HZ)) f = 32'(FREQ_MIN_HZ);
    v = 32'(req.vol);
    if (v > 32'(VOLUME_MAX)) v = 32'(VOLUME_MAX);
    if (f < 32'(FREQ_LOW_HZ)) factor = 32'(FACTOR_LOW);
    else if (f < 32'(FREQ_MID_HZ)) factor = 32'(FACTOR_MID);
    else factor = 32'(FACTOR_HIGH);
    quot   = clock_hz / (f * factor);
    // low half of the quotient minus one, wrapping
    period = quot[15:0] - 16'd1;
    pulse  = (32'(period) / PULSE_DIV) * v;
    r.period = period;
    r.pulse  = pulse[PULSE_W-1:0];
    r.freq   = f[FREQ_W-1:0];
    r.vol    = v[VOL_W-1:0];
    r.ovf    = (quot > 32'hFFFF) || (quot == 32'd0);
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // request driver: a presented request stays put until taken
  always @(negedge clk) begin : req_driver
    tone_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tone_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tone_req_q.pop_front();
        in_valid     <= 1'b1;
        tone_freq_hz <= nxt.freq;
        loudness     <= nxt.vol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, with one long hold-off when armed
  always @(negedge clk) begin : result_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    timer_setting_t want;
    tone_req_t      req;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        req.freq = tone_freq_hz;
        req.vol  = loudness;
        timer_setting_q.push_back(calc_timer_setting(core_clock_model, req));
      end
      if (out_valid && !out_stall) begin
        if (timer_setting_q.size() == 0) begin
          note_failure($sformatf("unexpected result: period=%0d pulse=%0d freq=%0d vol=%0d ovf=%0d",
                                 period_count, pulse_count, freq_applied, volume_applied,
                                 period_overflow));
        end else begin
          want = timer_setting_q.pop_front();
          if (period_count !== want.period || pulse_count !== want.pulse ||
              freq_applied !== want.freq || volume_applied !== want.vol ||
              period_overflow !== want.ovf) begin
            note_failure($sformatf({"mismatch: exp period=%0d pulse=%0d freq=%0d vol=%0d ",
                                    "ovf=%0d, got period=%0d pulse=%0d freq=%0d vol=%0d ovf=%0d"},
                                   want.period, want.pulse, want.freq, want.vol, want.ovf,
                                   period_count, pulse_count, freq_applied, volume_applied,
                                   period_overflow));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic [FREQ_IN_W-1:0] f, input logic [VOL_IN_W-1:0] v);
    tone_req_t r;
    r.freq = f;
    r.vol  = v;
    tone_req_q.push_back(r);
  endtask

  task automatic set_core_clock(input logic [CLK_W-1:0] hz);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    core_clock_model = hz;
  endtask

  // wait for every request to go in and every result to come out
  task automatic settle_pipeline();
    int waited;
    waited = 0;
    while (tone_req_q.size() != 0 || in_valid) @(posedge clk);
    while (timer_setting_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (timer_setting_q.size() != 0) begin
      note_failure("expected result never arrived");
      void'(timer_setting_q.pop_front());
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [FREQ_IN_W-1:0] rand_freq();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(199, 0);
      2: return $urandom_range(10100, 9900);
      3: return $urandom_range(505, 495);
      4: return $urandom_range(2005, 1995);
      default: return $urandom_range(10000, 200);
    endcase
  endfunction

  function automatic logic [VOL_IN_W-1:0] rand_vol();
    case ($urandom_range(7))
      0: return VOL_IN_W'($urandom_range(16'hFFFF, 0));
      1: return VOL_IN_W'($urandom_range(120, 95));
      default: return VOL_IN_W'($urandom_range(100, 0));
    endcase
  endfunction

  initial begin
    logic [CLK_W-1:0] seg_clock[6];
    seg_clock[0] = 32'hFFFF_FFFF;
    seg_clock[1] = 32'd1;
    seg_clock[2] = 32'd2000000;
    seg_clock[3] = CLOCK_RESET_HZ;
    seg_clock[4] = $urandom_range(1400000000, 1);
    seg_clock[5] = $urandom_range(32'hFFFF_FFFF, 1);

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: band edges and volume clamp at the reset clock
    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_req(32'd0, 16'd0);
    push_req(32'd199, 16'd100);
    push_req(32'd200, 16'd101);
    push_req(32'd499, 16'd50);
    push_req(32'd500, 16'hFFFF);
    push_req(32'd1999, 16'd1);
    push_req(32'd2000, 16'd99);
    push_req(32'd10000, 16'd100);
    push_req(32'd10001, 16'd7);
    push_req(32'hFFFF_FFFF, 16'hFFFF);
    push_req(32'h8000_0000, 16'h8000);
    push_req(32'd4000, 16'h7F7F);
    settle_pipeline();

    // clock below the divisor: zero quotient
    set_core_clock(32'd1);
    push_req(32'd200, 16'd100);
    push_req(32'd10000, 16'd100);
    push_req(32'd5000, 16'd37);
    settle_pipeline();

    // quotient just past 16 bits, then exactly 65535
    set_core_clock(32'd1310720000);
    push_req(32'd10000, 16'd100);
    push_req(32'd9999, 16'd64);
    settle_pipeline();
    set_core_clock(32'd1310700000);
    push_req(32'd10000, 16'd100);
    push_req(32'd20000, 16'd3);
    settle_pipeline();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 28;
        recv_idle_pct = 47;
      end else if (seg < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_core_clock(seg_clock[seg]);
      // long output hold-off while the sender keeps offering requests
      if (seg == 4) hold_armed = 1'b1;
      for (int i = 0; i < SEG_ITEMS; i++) push_req(rand_freq(), rand_vol());
      settle_pipeline();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
